### design/pcc_pkg.sv
// Shared types, codes and helpers for the password composition checker.
// No dependencies; every other design file uses it through scoped names.
`default_nettype none

package pcc_pkg;

	// Bytes of one password that take part in the checks.
	localparam int SIG_CHARS = 256;
	localparam int SEEN_W    = $clog2(SIG_CHARS + 1);

	localparam int CNT_W  = 9;
	localparam int CFG_W  = 9;
	localparam int ADDR_W = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [ADDR_W-1:0] {
		CFG_MIN_ALPHA    = 3'd0,
		CFG_MIN_UPPER    = 3'd1,
		CFG_MIN_LOWER    = 3'd2,
		CFG_MIN_NONALPHA = 3'd3,
		CFG_MIN_SPECIAL  = 3'd4,
		CFG_MIN_DIGIT    = 3'd5,
		CFG_MAX_REPEAT   = 3'd6,
		CFG_WS_ALLOWED   = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		VERDICT_OK       = 4'd0,
		VERDICT_SPACE    = 4'd1,
		VERDICT_ALPHA    = 4'd2,
		VERDICT_NONALPHA = 4'd3,
		VERDICT_SPECIAL  = 4'd4,
		VERDICT_DIGIT    = 4'd5,
		VERDICT_UPPER    = 4'd6,
		VERDICT_LOWER    = 4'd7,
		VERDICT_REPEAT   = 4'd8
	} verdict_t;

	typedef enum logic [2:0] {
		CLS_UPPER   = 3'd0,
		CLS_LOWER   = 3'd1,
		CLS_SPACE   = 3'd2,
		CLS_DIGIT   = 3'd3,
		CLS_SPECIAL = 3'd4
	} cls_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic [7:0] char_byte;
		cls_t       cls;
		logic       first;
		logic       keep;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] min_alpha;
		logic [CFG_W-1:0] min_upper;
		logic [CFG_W-1:0] min_lower;
		logic [CFG_W-1:0] min_nonalpha;
		logic [CFG_W-1:0] min_special;
		logic [CFG_W-1:0] min_digit;
		logic [CFG_W-1:0] max_repeat;
		logic             ws_allowed;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] upper;
		logic [CNT_W-1:0] lower;
		logic [CNT_W-1:0] space;
		logic [CNT_W-1:0] digit;
		logic [CNT_W-1:0] special;
		logic [CNT_W-1:0] run;
		logic [CNT_W-1:0] max_run;
		logic [7:0]       prev;
	} counts_t;

	// Register values after reset.
	localparam cfg_t CFG_RESET = '{
		min_alpha:    CFG_W'(2),
		min_upper:    '0,
		min_lower:    '0,
		min_nonalpha: CFG_W'(1),
		min_special:  '0,
		min_digit:    '0,
		max_repeat:   '0,
		ws_allowed:   1'b1
	};

	// Counters at the start of every password.
	localparam counts_t COUNTS_CLEAR = '{
		upper:   '0,
		lower:   '0,
		space:   '0,
		digit:   '0,
		special: '0,
		run:     CNT_W'(1),
		max_run: '0,
		prev:    '0
	};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

### design/pcc_front.sv
// Input side: accepts password bytes, classes them and tracks position.
// Uses pcc_pkg; feeds pcc_fifo.
`default_nettype none

module pcc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] char_byte
	input  wire logic              s_tlast,   // last_char
	input  wire logic              fifo_full,
	output logic                   push,
	output pcc_pkg::item_t         push_item
);

	logic [pcc_pkg::SEEN_W-1:0] seen_q;
	logic                       keep;
	pcc_pkg::cls_t              cls;

	assign s_tready = !fifo_full;
	assign push     = s_tvalid && s_tready;
	assign keep     = seen_q < pcc_pkg::SEEN_W'(pcc_pkg::SIG_CHARS);

	always_comb begin
		if (s_tdata inside {[8'h41:8'h5A]}) begin
			cls = pcc_pkg::CLS_UPPER;
		end else if (s_tdata inside {[8'h61:8'h7A]}) begin
			cls = pcc_pkg::CLS_LOWER;
		end else if (s_tdata inside {8'h20, [8'h09:8'h0D]}) begin
			cls = pcc_pkg::CLS_SPACE;
		end else if (s_tdata inside {[8'h30:8'h39]}) begin
			cls = pcc_pkg::CLS_DIGIT;
		end else begin
			cls = pcc_pkg::CLS_SPECIAL;
		end
	end

	always_comb begin
		push_item.char_byte = s_tdata;
		push_item.cls       = cls;
		push_item.first     = (seen_q == '0);
		push_item.keep      = keep;
		push_item.last      = s_tlast;
	end

	// Position within the password; stops at the significant length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				seen_q <= '0;
			end else if (keep) begin
				seen_q <= seen_q + pcc_pkg::SEEN_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### design/pcc_fifo.sv
// Short queue of classified words between front and back.
// Uses pcc_pkg for the item type and depth.
`default_nettype none

module pcc_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pcc_pkg::item_t push_item,
	input  wire logic           pop,
	output pcc_pkg::item_t      head,
	output logic                empty,
	output logic                full
);

	pcc_pkg::item_t               mem [pcc_pkg::FIFO_DEPTH];
	logic [pcc_pkg::PTR_W-1:0]    wr_ptr_q;
	logic [pcc_pkg::PTR_W-1:0]    rd_ptr_q;
	logic [pcc_pkg::FCNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == pcc_pkg::FCNT_W'(pcc_pkg::FIFO_DEPTH));
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pcc_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pcc_pkg::PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + pcc_pkg::FCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - pcc_pkg::FCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### design/pcc_back.sv
// Counting side: keeps class counts and repeat runs, judges each password
// and holds the verdict in an output register. Uses pcc_pkg.
`default_nettype none

module pcc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pcc_pkg::cfg_t  cfg,
	input  wire pcc_pkg::item_t head,
	input  wire logic           empty,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [15:0]         m_tdata    // [3:0] verdict, [4] passed, [13:5] longest_run
);

	pcc_pkg::counts_t cnt_q;
	pcc_pkg::counts_t nxt;
	pcc_pkg::verdict_t verdict;
	logic             out_valid_q;
	logic [3:0]       verdict_q;
	logic             passed_q;
	logic [8:0]       run_q;
	logic [9:0]       alpha_sum;
	logic [10:0]      nonalpha_sum;
	logic [9:0]       special_sum;

	// A non-final word never waits on the output register.
	assign pop      = !empty && (!head.last || !out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, run_q, passed_q, verdict_q};

	always_comb begin
		nxt = cnt_q;
		if (head.keep) begin
			case (head.cls)
				pcc_pkg::CLS_UPPER:   nxt.upper   = pcc_pkg::sat_inc(cnt_q.upper);
				pcc_pkg::CLS_LOWER:   nxt.lower   = pcc_pkg::sat_inc(cnt_q.lower);
				pcc_pkg::CLS_SPACE:   nxt.space   = pcc_pkg::sat_inc(cnt_q.space);
				pcc_pkg::CLS_DIGIT:   nxt.digit   = pcc_pkg::sat_inc(cnt_q.digit);
				default:              nxt.special = pcc_pkg::sat_inc(cnt_q.special);
			endcase
			if (!head.first && head.char_byte == cnt_q.prev) begin
				nxt.run = pcc_pkg::sat_inc(cnt_q.run);
				if (nxt.run > cnt_q.max_run) begin
					nxt.max_run = nxt.run;
				end
			end else begin
				nxt.run = pcc_pkg::CNT_W'(1);
			end
			nxt.prev = head.char_byte;
		end
	end

	always_comb begin
		alpha_sum    = {1'b0, nxt.upper} + {1'b0, nxt.lower};
		special_sum  = {1'b0, nxt.special} + {1'b0, nxt.space};
		nonalpha_sum = {1'b0, special_sum} + {2'b00, nxt.digit};
		if (nxt.space != '0 && !cfg.ws_allowed) begin
			verdict = pcc_pkg::VERDICT_SPACE;
		end else if (alpha_sum < {1'b0, cfg.min_alpha}) begin
			verdict = pcc_pkg::VERDICT_ALPHA;
		end else if (cfg.min_nonalpha != '0
				&& nonalpha_sum < {2'b00, cfg.min_nonalpha}) begin
			verdict = pcc_pkg::VERDICT_NONALPHA;
		end else if (cfg.min_nonalpha == '0
				&& special_sum < {1'b0, cfg.min_special}) begin
			verdict = pcc_pkg::VERDICT_SPECIAL;
		end else if (cfg.min_nonalpha == '0 && nxt.digit < cfg.min_digit) begin
			verdict = pcc_pkg::VERDICT_DIGIT;
		end else if (nxt.upper < cfg.min_upper) begin
			verdict = pcc_pkg::VERDICT_UPPER;
		end else if (nxt.lower < cfg.min_lower) begin
			verdict = pcc_pkg::VERDICT_LOWER;
		end else if (cfg.max_repeat != '0 && nxt.max_run > cfg.max_repeat) begin
			verdict = pcc_pkg::VERDICT_REPEAT;
		end else begin
			verdict = pcc_pkg::VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= pcc_pkg::COUNTS_CLEAR;
		end else if (pop) begin
			if (head.last) begin
				cnt_q <= pcc_pkg::COUNTS_CLEAR;
			end else begin
				cnt_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			verdict_q <= verdict;
			passed_q  <= (verdict == pcc_pkg::VERDICT_OK);
			run_q     <= nxt.max_run;
		end
	end

endmodule

`default_nettype wire

### design/password_composition_checker_unit.sv
// Password composition checker, top level.
// Channels: s_* takes one password byte per word in s_tdata[7:0], with
// s_tlast on the final byte. m_* gives one verdict word per password:
// verdict in [3:0], passed in [4], longest run of equal bytes in [13:5].
// Only the first 256 bytes of a password are counted; s_tlast still ends it.
// Config: cfg_we writes cfg_wdata into register cfg_addr (min_alpha,
// min_upper, min_lower, min_nonalpha, min_special, min_digit, max_repeat,
// whitespace_allowed, indexes 0 to 7); the user must write only while the
// block is idle, which the block itself does not enforce. Throughput: one
// byte per cycle unless the output stalls. The front classes a byte in the
// cycle it is accepted and pushes it into a four-entry queue; the back
// pops one word per cycle, a final word only once the output register is
// free, counts it, and on a final byte judges the password and loads the
// output register, which drives m_tvalid. Stall: while m_tready is low
// the verdict holds; the back keeps counting the next password until its
// final byte, then the queue fills and s_tready drops. Reset clears
// counters, queue and output valid and loads the register defaults; no
// clearing pass is needed. Uses pcc_pkg, pcc_front, pcc_fifo and pcc_back.
`default_nettype none

module password_composition_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] char_byte
	input  wire logic        s_tlast,    // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,    // [3:0] verdict, [4] passed, [13:5] longest_run
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [8:0]  cfg_wdata
);

	pcc_pkg::cfg_t  cfg_q;
	pcc_pkg::item_t push_item;
	pcc_pkg::item_t head;
	logic           push;
	logic           pop;
	logic           empty;
	logic           full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pcc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (pcc_pkg::cfg_idx_t'(cfg_addr))
				pcc_pkg::CFG_MIN_ALPHA:    cfg_q.min_alpha    <= cfg_wdata;
				pcc_pkg::CFG_MIN_UPPER:    cfg_q.min_upper    <= cfg_wdata;
				pcc_pkg::CFG_MIN_LOWER:    cfg_q.min_lower    <= cfg_wdata;
				pcc_pkg::CFG_MIN_NONALPHA: cfg_q.min_nonalpha <= cfg_wdata;
				pcc_pkg::CFG_MIN_SPECIAL:  cfg_q.min_special  <= cfg_wdata;
				pcc_pkg::CFG_MIN_DIGIT:    cfg_q.min_digit    <= cfg_wdata;
				pcc_pkg::CFG_MAX_REPEAT:   cfg_q.max_repeat   <= cfg_wdata;
				pcc_pkg::CFG_WS_ALLOWED:   cfg_q.ws_allowed   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	pcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.fifo_full (full),
		.push      (push),
		.push_item (push_item)
	);

	pcc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	pcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A run of one is never reported: the run is zero or at least two.
	a_run_not_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:5] != 9'd1)
		else $error("longest run of one reported");

	// A repeat failure needs a run longer than the nonzero limit.
	a_repeat_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:0] == pcc_pkg::VERDICT_REPEAT
		|-> m_tdata[13:5] > cfg_q.max_repeat && cfg_q.max_repeat != '0)
		else $error("repeat verdict without a long run");

	// Passed agrees with the verdict code.
	a_passed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4] == (m_tdata[3:0] == pcc_pkg::VERDICT_OK))
		else $error("passed flag disagrees with verdict");

	// Nothing reaches the output while the queue and output are empty.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && empty |=> !m_tvalid)
		else $error("verdict without a queued word");

endmodule

`default_nettype wire
